@@ src/sgme_pkg.sv @@
package sgme_pkg;

    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int COLS_W      = 7;
    localparam int ROW_W       = 11;
    localparam int CNT_W       = 17;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] NEIGH = 4'd8;

    localparam logic [1:0] REG_ROWS      = 2'd0;
    localparam logic [1:0] REG_COLS      = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    // One completed interior row, ready for evaluation
    typedef struct packed {
        logic [MAX_COLS-1:0] up;
        logic [MAX_COLS-1:0] mid;
        logic [MAX_COLS-1:0] dn;
        logic [ROW_W-1:0]    row;
        logic                frame_end;
    } job_t;

endpackage

@@ src/sgme_front.sv @@
module sgme_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         color_bit,
    input  logic [sgme_pkg::ROW_W-1:0]   rows_eff,
    input  logic [sgme_pkg::COLS_W-1:0]  cols_eff,
    input  logic                         q_full,
    output logic                         push,
    output sgme_pkg::job_t               job
);

    logic [sgme_pkg::MAX_COLS-1:0] up_reg, up_next;
    logic [sgme_pkg::MAX_COLS-1:0] mid_reg, mid_next;
    logic [sgme_pkg::MAX_COLS-1:0] fill_reg, fill_next;
    logic [sgme_pkg::COL_W-1:0]    col_reg, col_next;
    logic [sgme_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [sgme_pkg::MAX_COLS-1:0] filled;
    logic                          accept;
    logic                          row_done;
    logic                          frame_end;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        filled          = fill_reg;
        filled[col_reg] = color_bit;
        row_done  = ({1'b0, col_reg} + {{(sgme_pkg::COLS_W-1){1'b0}}, 1'b1}) >= cols_eff;
        frame_end = {1'b0, row_reg} >= ({1'b0, rows_eff} + {{sgme_pkg::ROW_W{1'b0}}, 1'b1});

        job.up        = up_reg;
        job.mid       = mid_reg;
        job.dn        = filled;
        job.row       = row_reg - {{(sgme_pkg::ROW_W-1){1'b0}}, 1'b1};
        job.frame_end = frame_end;
        push = accept && row_done && (row_reg >= sgme_pkg::ROW_W'(2));

        up_next   = up_reg;
        mid_next  = mid_reg;
        fill_next = fill_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept)
        begin
            if (!row_done)
            begin
                fill_next = filled;
                col_next  = col_reg + {{(sgme_pkg::COL_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                // shift line stores and open a fresh row
                up_next   = mid_reg;
                mid_next  = filled;
                fill_next = '0;
                col_next  = '0;
                row_next  = frame_end ? '0 : row_reg + {{(sgme_pkg::ROW_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= '0;
            mid_reg  <= '0;
            fill_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            up_reg   <= up_next;
            mid_reg  <= mid_next;
            fill_reg <= fill_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

endmodule

@@ src/sgme_queue.sv @@
module sgme_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sgme_pkg::job_t  push_job,
    input  logic            pop,
    output sgme_pkg::job_t  head_job,
    output logic            empty,
    output logic            full
);

    localparam int PTR_W = (sgme_pkg::QUEUE_DEPTH > 1) ? $clog2(sgme_pkg::QUEUE_DEPTH) : 1;

    sgme_pkg::job_t   slot_reg [sgme_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(sgme_pkg::QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + {{(PTR_W-1){1'b0}}, 1'b1};
        return r;
    endfunction

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == (PTR_W+1)'(sgme_pkg::QUEUE_DEPTH));
    assign head_job = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = (push && !full) ? ptr_inc(wr_reg) : wr_reg;
        rd_next  = (pop && !empty) ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg;
        if ((push && !full) && !(pop && !empty))
            cnt_next = cnt_reg + {{PTR_W{1'b0}}, 1'b1};
        else if (!(push && !full) && (pop && !empty))
            cnt_next = cnt_reg - {{PTR_W{1'b0}}, 1'b1};
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/sgme_back.sv @@
module sgme_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sgme_pkg::job_t               head_job,
    input  logic                         q_empty,
    output logic                         pop,
    input  logic [sgme_pkg::COLS_W-1:0]  cols_eff,
    input  logic [3:0]                   threshold,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sgme_pkg::ROW_W-1:0]   cell_row,
    output logic [sgme_pkg::COL_W-1:0]   cell_column,
    output logic                         own_color,
    output logic                         wants_move,
    output logic [sgme_pkg::CNT_W-1:0]   movers_color0,
    output logic [sgme_pkg::CNT_W-1:0]   movers_color1,
    output logic                         row_last,
    output logic                         frame_last
);

    sgme_pkg::job_t               job_reg;
    logic                         busy_reg, busy_next;
    logic [sgme_pkg::COL_W-1:0]   col_reg, col_next;
    logic [sgme_pkg::CNT_W-1:0]   cnt0_reg, cnt0_next;
    logic [sgme_pkg::CNT_W-1:0]   cnt1_reg, cnt1_next;
    logic                         ov_reg, ov_next;

    logic [sgme_pkg::ROW_W-1:0]   o_row_reg;
    logic [sgme_pkg::COL_W-1:0]   o_col_reg;
    logic                         o_own_reg, o_mv_reg, o_rlast_reg, o_flast_reg;
    logic [sgme_pkg::CNT_W-1:0]   o_c0_reg, o_c1_reg;

    logic                         advance;
    logic [sgme_pkg::COLS_W-1:0]  col_plus;
    logic                         is_last;
    logic [sgme_pkg::COL_W-1:0]   lcol, rcol;
    logic [3:0]                   ones, unlike;
    logic                         own, mv;
    logic [sgme_pkg::CNT_W-1:0]   c0_upd, c1_upd;

    assign advance = busy_reg && (!ov_reg || !out_stall);
    assign pop     = !busy_reg && !q_empty;

    always_comb
    begin
        col_plus = {1'b0, col_reg} + {{(sgme_pkg::COLS_W-1){1'b0}}, 1'b1};
        is_last  = (col_plus >= cols_eff);
        lcol = (col_reg == '0) ? sgme_pkg::COL_W'(cols_eff - {{(sgme_pkg::COLS_W-1){1'b0}}, 1'b1})
                               : col_reg - {{(sgme_pkg::COL_W-1){1'b0}}, 1'b1};
        rcol = is_last ? '0 : col_plus[sgme_pkg::COL_W-1:0];
        ones = {3'b0, job_reg.up[lcol]} + {3'b0, job_reg.up[col_reg]} + {3'b0, job_reg.up[rcol]}
             + {3'b0, job_reg.mid[lcol]} + {3'b0, job_reg.mid[rcol]}
             + {3'b0, job_reg.dn[lcol]} + {3'b0, job_reg.dn[col_reg]} + {3'b0, job_reg.dn[rcol]};
        own    = job_reg.mid[col_reg];
        unlike = own ? (sgme_pkg::NEIGH - ones) : ones;
        mv     = (unlike >= threshold);

        // saturate the mover tallies
        c0_upd = cnt0_reg;
        c1_upd = cnt1_reg;
        if (mv && !own && (cnt0_reg != '1))
            c0_upd = cnt0_reg + {{(sgme_pkg::CNT_W-1){1'b0}}, 1'b1};
        if (mv && own && (cnt1_reg != '1))
            c1_upd = cnt1_reg + {{(sgme_pkg::CNT_W-1){1'b0}}, 1'b1};

        busy_next = busy_reg;
        col_next  = col_reg;
        cnt0_next = cnt0_reg;
        cnt1_next = cnt1_reg;
        ov_next   = ov_reg && out_stall;
        if (pop)
        begin
            busy_next = 1'b1;
            col_next  = '0;
        end
        else if (advance)
        begin
            ov_next   = 1'b1;
            col_next  = col_plus[sgme_pkg::COL_W-1:0];
            cnt0_next = c0_upd;
            cnt1_next = c1_upd;
            if (is_last)
            begin
                busy_next = 1'b0;
                if (job_reg.frame_end)
                begin
                    cnt0_next = '0;
                    cnt1_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            cnt0_reg <= '0;
            cnt1_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
            cnt0_reg <= cnt0_next;
            cnt1_reg <= cnt1_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head_job;
        if (advance)
        begin
            o_row_reg   <= job_reg.row;
            o_col_reg   <= col_reg;
            o_own_reg   <= own;
            o_mv_reg    <= mv;
            o_c0_reg    <= c0_upd;
            o_c1_reg    <= c1_upd;
            o_rlast_reg <= is_last;
            o_flast_reg <= is_last && job_reg.frame_end;
        end
    end

    assign out_valid     = ov_reg;
    assign cell_row      = o_row_reg;
    assign cell_column   = o_col_reg;
    assign own_color     = o_own_reg;
    assign wants_move    = o_mv_reg;
    assign movers_color0 = o_c0_reg;
    assign movers_color1 = o_c1_reg;
    assign row_last      = o_rlast_reg;
    assign frame_last    = o_flast_reg;

endmodule

@@ src/segregation_grid_move_evaluator.sv @@
// Channel   Signals                                        Handshake
// input     color_bit                                      in_valid / in_stall
// output    cell_row, cell_column, own_color, wants_move,  out_valid / out_stall
//           movers_color0, movers_color1, row_last, frame_last
// config    cfg_index, cfg_data                            cfg_valid / cfg_ready
//
// A row of N cells is taken one beat per cycle while in_stall is low; the back unit
// then loads the row from the queue and evaluates it column by column.
// A two-row queue overlaps filling of the next row with evaluation of the last, so
// cells of the next row are accepted while the back unit still works on the last.
// Reset clears positions, line stores, counters and loads the register defaults.
// in_stall rises while the queue holds two rows; out_stall holds the output register.
module segregation_grid_move_evaluator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         color_bit,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sgme_pkg::ROW_W-1:0]   cell_row,
    output logic [sgme_pkg::COL_W-1:0]   cell_column,
    output logic                         own_color,
    output logic                         wants_move,
    output logic [sgme_pkg::CNT_W-1:0]   movers_color0,
    output logic [sgme_pkg::CNT_W-1:0]   movers_color1,
    output logic                         row_last,
    output logic                         frame_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [sgme_pkg::ROW_W-1:0]   cfg_data
);

    logic [sgme_pkg::ROW_W-1:0]   rows_reg;
    logic [sgme_pkg::COLS_W-1:0]  cols_reg;
    logic [3:0]                   thr_reg;
    logic [sgme_pkg::ROW_W-1:0]   rows_eff;
    logic [sgme_pkg::COLS_W-1:0]  cols_eff;

    logic            push, pop, q_full, q_empty;
    sgme_pkg::job_t  push_job, head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= sgme_pkg::ROW_W'(64);
            cols_reg <= sgme_pkg::COLS_W'(64);
            thr_reg  <= 4'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sgme_pkg::REG_ROWS:      rows_reg <= cfg_data;
                sgme_pkg::REG_COLS:      cols_reg <= cfg_data[sgme_pkg::COLS_W-1:0];
                sgme_pkg::REG_THRESHOLD: thr_reg  <= cfg_data[3:0];
                default:                 ;
            endcase
        end
    end

    // clamp register values into the supported grid size
    always_comb
    begin
        if (cols_reg < sgme_pkg::COLS_W'(2))
            cols_eff = sgme_pkg::COLS_W'(2);
        else if (cols_reg > sgme_pkg::COLS_W'(sgme_pkg::MAX_COLS))
            cols_eff = sgme_pkg::COLS_W'(sgme_pkg::MAX_COLS);
        else
            cols_eff = cols_reg;

        if (rows_reg == '0)
            rows_eff = sgme_pkg::ROW_W'(1);
        else if (rows_reg > sgme_pkg::ROW_W'(sgme_pkg::MAX_ROWS))
            rows_eff = sgme_pkg::ROW_W'(sgme_pkg::MAX_ROWS);
        else
            rows_eff = rows_reg;
    end

    sgme_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .color_bit  (color_bit),
        .rows_eff   (rows_eff),
        .cols_eff   (cols_eff),
        .q_full     (q_full),
        .push       (push),
        .job        (push_job)
    );

    sgme_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    sgme_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .q_empty       (q_empty),
        .pop           (pop),
        .cols_eff      (cols_eff),
        .threshold     (thr_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_row      (cell_row),
        .cell_column   (cell_column),
        .own_color     (own_color),
        .wants_move    (wants_move),
        .movers_color0 (movers_color0),
        .movers_color1 (movers_color1),
        .row_last      (row_last),
        .frame_last    (frame_last)
    );

endmodule
